/* hdl/rbn_pkg.sv */
// Shared types, constants and helpers for the bilinear resize and normalize unit.
package rbn_pkg;

	// Command codes carried on the request channel.
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PRODUCE = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_OUT_N = 2'd2;

	// Dimension limits and reset values.
	localparam logic [8:0] DIM_MAX     = 9'd256;
	localparam logic [8:0] SRC_W_RESET = 9'd256;
	localparam logic [8:0] SRC_H_RESET = 9'd256;
	localparam logic [8:0] OUT_N_RESET = 9'd224;

	// Weight of one full pixel step (eight fraction bits).
	localparam logic [8:0] WEIGHT_ONE = 9'd256;

	// Normalization: 255 in blend units, rounding half of 1020, reciprocal of 255.
	localparam logic [24:0] FULL_SCALE  = 25'd16711680;
	localparam logic [24:0] ROUND_HALF  = 25'd510;
	localparam logic [15:0] RECIP_255   = 16'd32897;

	// One mapped beat between the divider and the fetch unit.
	typedef struct packed {
		logic        load;
		logic        err;
		logic [15:0] idx;
		logic [23:0] word;
		logic [7:0]  x0;
		logic [7:0]  x1;
		logic [7:0]  y0;
		logic [7:0]  y1;
		logic [7:0]  fx;
		logic [7:0]  fy;
	} map_t;

	// One blended beat between the fetch unit and the normalizer.
	typedef struct packed {
		logic             err;
		logic [2:0][23:0] sum;
	} acc_t;

	// Zero acts as one and values above the limit act as the limit.
	function automatic logic [8:0] eff_dim(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (v > DIM_MAX) begin
			r = DIM_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* hdl/rbn_if.sv */
// Request and response channel interfaces.
interface rbn_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] pixel_index;
	logic [31:0] pixel_word;
	logic [7:0]  out_column;
	logic [7:0]  out_row;

	modport source(output valid, command, pixel_index, pixel_word, out_column, out_row,
		input ready);
	modport sink(input valid, command, pixel_index, pixel_word, out_column, out_row,
		output ready);
endinterface

interface rbn_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] red_value;
	logic signed [15:0] green_value;
	logic signed [15:0] blue_value;
	logic               coord_error;

	modport source(output valid, red_value, green_value, blue_value, coord_error,
		input ready);
	modport sink(input valid, red_value, green_value, blue_value, coord_error,
		output ready);
endinterface

/* hdl/rbn_div.sv */
// Coordinate mapper: divides o*(S-1)*256 by (D-1), eight quotient bits a cycle.
module rbn_div import rbn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] src_w,
	input  logic [8:0] src_h,
	input  logic [8:0] out_n,
	rbn_req_if.sink    req,
	output logic       map_valid,
	output map_t       map_item,
	input  logic       map_ready
);

	logic        busy_q;
	logic [1:0]  left_q;
	logic        load_q;
	logic        err_q;
	logic [15:0] idx_q;
	logic [23:0] word_q;
	logic [7:0]  d_q;
	logic [7:0]  rx_q;
	logic [7:0]  ry_q;
	logic [15:0] nlx_q;
	logic [15:0] nly_q;
	logic [15:0] qx_q;
	logic [15:0] qy_q;

	logic        done;
	logic        take;
	logic        coord_bad;
	logic [15:0] nx;
	logic [15:0] ny;
	logic [39:0] stx;
	logic [39:0] sty;
	logic [8:0]  x0p1;
	logic [8:0]  y0p1;

	// Eight restoring division steps on remainder, numerator tail and quotient.
	function automatic logic [39:0] div8(input logic [7:0] r_in, input logic [15:0] nl_in,
		input logic [15:0] q_in, input logic [7:0] d);
		logic [7:0]  r;
		logic [15:0] nl;
		logic [15:0] q;
		logic [8:0]  t;
		r  = r_in;
		nl = nl_in;
		q  = q_in;
		for (int i = 0; i < 8; i++) begin
			t  = {r, nl[15]};
			nl = {nl[14:0], 1'b0};
			if (t >= {1'b0, d}) begin
				r = 8'(t - {1'b0, d});
				q = {q[14:0], 1'b1};
			end else begin
				r = t[7:0];
				q = {q[14:0], 1'b0};
			end
		end
		return {r, nl, q};
	endfunction

	// Range check and numerators of both axes.
	always_comb begin
		coord_bad = ({1'b0, req.out_column} >= out_n) || ({1'b0, req.out_row} >= out_n);
		if (out_n == 9'd1) begin
			nx = '0;
			ny = '0;
		end else begin
			nx = 16'(req.out_column) * 16'(src_w - 9'd1);
			ny = 16'(req.out_row) * 16'(src_h - 9'd1);
		end
	end

	assign done      = busy_q && (left_q == 2'd0);
	assign req.ready = !busy_q || (done && map_ready);
	assign take      = req.valid && req.ready;
	assign stx       = div8(rx_q, nlx_q, qx_q, d_q);
	assign sty       = div8(ry_q, nly_q, qy_q, d_q);

	// Occupancy and remaining division cycles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			left_q <= 2'd0;
		end else if (take) begin
			busy_q <= 1'b1;
			left_q <= (req.command == CMD_PRODUCE && !coord_bad) ? 2'd2 : 2'd0;
		end else if (done && map_ready) begin
			busy_q <= 1'b0;
		end else if (left_q != 2'd0) begin
			left_q <= left_q - 2'd1;
		end
	end

	// Beat payload and division datapath.
	always_ff @(posedge clk) begin
		if (take) begin
			load_q <= (req.command == CMD_LOAD);
			err_q  <= (req.command == CMD_PRODUCE) && coord_bad;
			idx_q  <= req.pixel_index;
			word_q <= req.pixel_word[23:0];
			d_q    <= (out_n == 9'd1) ? 8'd1 : 8'(out_n - 9'd1);
			rx_q   <= nx[15:8];
			ry_q   <= ny[15:8];
			nlx_q  <= {nx[7:0], 8'h00};
			nly_q  <= {ny[7:0], 8'h00};
			qx_q   <= '0;
			qy_q   <= '0;
		end else if (busy_q && left_q != 2'd0) begin
			{rx_q, nlx_q, qx_q} <= stx;
			{ry_q, nly_q, qy_q} <= sty;
		end
	end

	// Neighbor coordinates clamped to the source edge.
	always_comb begin
		x0p1 = {1'b0, qx_q[15:8]} + 9'd1;
		y0p1 = {1'b0, qy_q[15:8]} + 9'd1;
		map_item.load = load_q;
		map_item.err  = err_q;
		map_item.idx  = idx_q;
		map_item.word = word_q;
		map_item.x0   = qx_q[15:8];
		map_item.y0   = qy_q[15:8];
		map_item.fx   = qx_q[7:0];
		map_item.fy   = qy_q[7:0];
		map_item.x1   = (x0p1 < src_w) ? x0p1[7:0] : 8'(src_w - 9'd1);
		map_item.y1   = (y0p1 < src_h) ? y0p1[7:0] : 8'(src_h - 9'd1);
	end

	assign map_valid = done;

endmodule

/* hdl/rbn_fetch.sv */
// Image store with one port: pixel writes, four corner reads and the weighted blend.
module rbn_fetch import rbn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] src_w,
	input  logic       map_valid,
	input  map_t       map_item,
	output logic       map_ready,
	output logic       acc_valid,
	output acc_t       acc_item,
	input  logic       acc_ready
);

	logic [23:0] mem [65536];

	logic             slot_q;
	map_t             item_q;
	logic [1:0]       phase_q;
	logic [23:0]      rdata_q;
	logic             s2_valid_q;
	logic             first_s2;
	logic             last_s2;
	logic             err_s2;
	logic [16:0]      w_s2;
	logic [2:0][23:0] acc_q;
	logic             res_valid_q;
	acc_t             res_q;

	logic             stall;
	logic             last_issue;
	logic             issue;
	logic             rd_en;
	logic [7:0]       xs;
	logic [7:0]       ys;
	logic [16:0]      row_base;
	logic [15:0]      rd_addr;
	logic [8:0]       wx;
	logic [8:0]       wy;
	logic [16:0]      w_next;
	logic [2:0][23:0] sum_next;

	assign stall      = res_valid_q && !acc_ready;
	assign last_issue = item_q.load || item_q.err || (phase_q == 2'd3);
	assign issue      = slot_q && !stall;
	assign rd_en      = issue && !item_q.load && !item_q.err;
	assign map_ready  = !slot_q || (issue && last_issue);

	// Slot occupancy and corner phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= 1'b0;
			phase_q <= 2'd0;
		end else if (map_valid && map_ready) begin
			slot_q  <= 1'b1;
			phase_q <= 2'd0;
		end else if (issue && last_issue) begin
			slot_q <= 1'b0;
		end else if (issue) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (map_valid && map_ready) begin
			item_q <= map_item;
		end
	end

	// Corner address and bilinear weight of this phase.
	always_comb begin
		xs       = phase_q[0] ? item_q.x1 : item_q.x0;
		ys       = phase_q[1] ? item_q.y1 : item_q.y0;
		row_base = 17'(ys) * 17'(src_w);
		rd_addr  = row_base[15:0] + 16'(xs);
		wx       = phase_q[0] ? {1'b0, item_q.fx} : WEIGHT_ONE - {1'b0, item_q.fx};
		wy       = phase_q[1] ? {1'b0, item_q.fy} : WEIGHT_ONE - {1'b0, item_q.fy};
		w_next   = 17'(18'(wx) * 18'(wy));
	end

	// Single port store: a write for a load beat, a registered read for an in-range produce beat.
	always_ff @(posedge clk) begin
		if (issue && item_q.load) begin
			mem[item_q.idx] <= item_q.word;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Weight and flags travel beside the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (!stall) begin
			s2_valid_q <= issue && !item_q.load;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			first_s2 <= (phase_q == 2'd0);
			last_s2  <= last_issue;
			err_s2   <= item_q.err;
			w_s2     <= w_next;
		end
	end

	// Per channel multiply and accumulate.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_next[c] = (first_s2 ? 24'd0 : acc_q[c])
				+ 24'(25'(rdata_q[8*c +: 8]) * 25'(w_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && s2_valid_q) begin
			acc_q <= sum_next;
		end
	end

	// Finished blend waits here for the normalizer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!stall && s2_valid_q && last_s2) begin
			res_valid_q <= 1'b1;
		end else if (acc_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && s2_valid_q && last_s2) begin
			res_q.err <= err_s2;
			res_q.sum <= sum_next;
		end
	end

	assign acc_valid = res_valid_q;
	assign acc_item  = res_q;

endmodule

/* hdl/rbn_norm.sv */
// Normalizer: maps each blend sum to 2v/255-1 in Q1.14, rounded to nearest.
module rbn_norm import rbn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    acc_valid,
	input  acc_t    acc_item,
	output logic    acc_ready,
	rbn_rsp_if.source rsp
);

	logic             valid_s1;
	logic             err_s1;
	logic [2:0]       neg_s1;
	logic [2:0][21:0] m_s1;
	logic             valid_s2;
	logic             err_s2;
	logic [2:0]       neg_s2;
	logic [2:0][21:0] m_s2;
	logic [2:0][37:0] prod_s2;
	logic             out_valid_q;
	logic             err_q;
	logic [2:0][15:0] val_q;

	logic             adv;
	logic [2:0]       neg_c;
	logic [2:0][21:0] m_c;
	logic [2:0][15:0] val_c;
	logic [24:0]      twice;
	logic [24:0]      mag;
	logic [24:0]      num;
	logic [14:0]      qe;
	logic [14:0]      q;
	logic [22:0]      chk;

	assign adv       = !out_valid_q || rsp.ready;
	assign acc_ready = adv;

	// Distance from mid scale, plus half the divisor, divided by four.
	always_comb begin
		twice = '0;
		mag   = '0;
		num   = '0;
		for (int c = 0; c < 3; c++) begin
			twice    = {acc_item.sum[c], 1'b0};
			neg_c[c] = twice < FULL_SCALE;
			mag      = neg_c[c] ? FULL_SCALE - twice : twice - FULL_SCALE;
			num      = mag + ROUND_HALF;
			m_c[c]   = num[23:2];
		end
	end

	// Quotient by 255 from the reciprocal, corrected by one where it overshoots.
	always_comb begin
		qe  = '0;
		q   = '0;
		chk = '0;
		for (int c = 0; c < 3; c++) begin
			qe  = prod_s2[c][37:23];
			chk = 23'({qe, 8'h00}) - 23'(qe);
			q   = (chk > 23'(m_s2[c])) ? qe - 15'd1 : qe;
			if (err_s2) begin
				val_c[c] = '0;
			end else if (neg_s2[c]) begin
				val_c[c] = 16'd0 - 16'(q);
			end else begin
				val_c[c] = 16'(q);
			end
		end
	end

	// Stage valids advance together whenever the output register can move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= acc_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			err_s1 <= acc_item.err;
			neg_s1 <= neg_c;
			m_s1   <= m_c;
			err_s2 <= err_s1;
			neg_s2 <= neg_s1;
			m_s2   <= m_s1;
			for (int c = 0; c < 3; c++) begin
				prod_s2[c] <= 38'(m_s1[c]) * 38'(RECIP_255);
			end
			err_q <= err_s2;
			val_q <= val_c;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.red_value   = val_q[0];
	assign rsp.green_value = val_q[1];
	assign rsp.blue_value  = val_q[2];
	assign rsp.coord_error = err_q;

endmodule

/* hdl/bilinear_resize_rgb_normalize_unit.sv */
// Top level of the bilinear resize and RGB normalize unit.
//
//   Channel  Direction  Carries
//   req      in         command, pixel_index, pixel_word, out_column, out_row
//   rsp      out        red_value, green_value, blue_value, coord_error
//   cfg      in         cfg_we, cfg_index, cfg_data (source width, height, output size)
//
// A produce beat in range occupies the single image memory port for one read
// per corner, and the fetch unit takes no new beat until its last read issues;
// a load beat, or a produce beat with a coordinate error, holds the port for a
// single issue.
// Reset clears all control state; the image memory is not cleared.
// A stalled rsp holds the result and backs up through the pipeline, while req
// still takes beats until the divider is full; empty normalizer stages stay empty.
module bilinear_resize_rgb_normalize_unit import rbn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rbn_req_if.sink    req,
	rbn_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	logic [8:0] src_w_q;
	logic [8:0] src_h_q;
	logic [8:0] out_n_q;
	logic [8:0] src_w;
	logic [8:0] src_h;
	logic [8:0] out_n;

	logic map_valid;
	map_t map_item;
	logic map_ready;
	logic acc_valid;
	acc_t acc_item;
	logic acc_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_W_RESET;
			src_h_q <= SRC_H_RESET;
			out_n_q <= OUT_N_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_W: src_w_q <= cfg_data;
				REG_SRC_H: src_h_q <= cfg_data;
				REG_OUT_N: out_n_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign src_w = eff_dim(src_w_q);
	assign src_h = eff_dim(src_h_q);
	assign out_n = eff_dim(out_n_q);

	rbn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_w     (src_w),
		.src_h     (src_h),
		.out_n     (out_n),
		.req       (req),
		.map_valid (map_valid),
		.map_item  (map_item),
		.map_ready (map_ready)
	);

	rbn_fetch u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_w     (src_w),
		.map_valid (map_valid),
		.map_item  (map_item),
		.map_ready (map_ready),
		.acc_valid (acc_valid),
		.acc_item  (acc_item),
		.acc_ready (acc_ready)
	);

	rbn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (acc_valid),
		.acc_item  (acc_item),
		.acc_ready (acc_ready),
		.rsp       (rsp)
	);

endmodule

/* tb/sv/rbn_checker.sv */
// Checker that mirrors the resize unit, predicts each response and compares it.
module rbn_checker import rbn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rbn_req_if         req,
	rbn_rsp_if         rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	output int         fail_count,
	output int         pending
);

	typedef struct packed {
		logic signed [15:0] red;
		logic signed [15:0] green;
		logic signed [15:0] blue;
		logic               err;
	} pixel_rsp_t;

	logic [23:0] image_mirror [0:65535];
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;
	logic [8:0]  side_reg;
	pixel_rsp_t  expected_pixels [$];

	assign pending = expected_pixels.size();

	// Register values of zero act as one and values above the limit act as the limit.
	function automatic int unsigned bounded_dim(input logic [8:0] v);
		int unsigned r;
		r = v;
		if (r == 0) r = 1;
		if (r > 256) r = 256;
		return r;
	endfunction

	// Blend sum to 2v/255-1 in Q1.14, rounded to nearest with ties away from zero.
	function automatic logic [15:0] to_q14(input longint unsigned blend);
		longint unsigned full;
		longint unsigned twice;
		longint unsigned mag;
		longint unsigned q;
		logic            neg;
		full  = 64'd255 << 16;
		twice = blend * 2;
		neg   = twice < full;
		mag   = neg ? full - twice : twice - full;
		q     = (mag + 510) / 1020;
		if (neg) q = -q;
		return q[15:0];
	endfunction

	// Corner-aligned mapping of one output coordinate and the bilinear blend.
	function automatic pixel_rsp_t resize_pixel(input logic [7:0] ox, input logic [7:0] oy);
		pixel_rsp_t      r;
		int unsigned     sw, sh, dn, x0, x1, y0, y1;
		longint unsigned px, py, fx, fy, w00, w01, w10, w11, blend;
		logic [23:0]     p00, p01, p10, p11;
		sw = bounded_dim(width_reg);
		sh = bounded_dim(height_reg);
		dn = bounded_dim(side_reg);
		r = '0;
		if (ox >= dn || oy >= dn) begin
			r.err = 1'b1;
			return r;
		end
		px = (dn <= 1) ? 0 : ((longint'(ox) * (sw - 1)) << 8) / (dn - 1);
		py = (dn <= 1) ? 0 : ((longint'(oy) * (sh - 1)) << 8) / (dn - 1);
		x0 = px >> 8;
		y0 = py >> 8;
		fx = px & 255;
		fy = py & 255;
		x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
		y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
		p00 = image_mirror[y0 * sw + x0];
		p01 = image_mirror[y0 * sw + x1];
		p10 = image_mirror[y1 * sw + x0];
		p11 = image_mirror[y1 * sw + x1];
		w00 = (256 - fx) * (256 - fy);
		w01 = fx * (256 - fy);
		w10 = (256 - fx) * fy;
		w11 = fx * fy;
		for (int c = 0; c < 3; c++) begin
			blend = p00[c*8 +: 8] * w00 + p01[c*8 +: 8] * w01
				+ p10[c*8 +: 8] * w10 + p11[c*8 +: 8] * w11;
			case (c)
				0: r.red = to_q14(blend);
				1: r.green = to_q14(blend);
				default: r.blue = to_q14(blend);
			endcase
		end
		return r;
	endfunction

	// Track register writes and accepted request beats.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  <= SRC_W_RESET;
			height_reg <= SRC_H_RESET;
			side_reg   <= OUT_N_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SRC_W: width_reg <= cfg_data;
					REG_SRC_H: height_reg <= cfg_data;
					REG_OUT_N: side_reg <= cfg_data;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.command == CMD_LOAD) begin
					image_mirror[req.pixel_index] = req.pixel_word[23:0];
				end else begin
					expected_pixels.push_back(resize_pixel(req.out_column, req.out_row));
				end
			end
		end
	end

	// Compare each response beat with the oldest prediction.
	initial fail_count = 0;
	always @(posedge clk) begin
		pixel_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("response beat with no request outstanding");
				fail_count++;
			end else begin
				e = expected_pixels.pop_front();
				if (rsp.red_value !== e.red) begin
					$error("red_value: expected %0d, got %0d", e.red, rsp.red_value);
					fail_count++;
				end
				if (rsp.green_value !== e.green) begin
					$error("green_value: expected %0d, got %0d", e.green, rsp.green_value);
					fail_count++;
				end
				if (rsp.blue_value !== e.blue) begin
					$error("blue_value: expected %0d, got %0d", e.blue, rsp.blue_value);
					fail_count++;
				end
				if (rsp.coord_error !== e.err) begin
					$error("coord_error: expected %0b, got %0b", e.err, rsp.coord_error);
					fail_count++;
				end
			end
		end
	end

endmodule

/* tb/sv/tb_bilinear_resize_rgb_normalize_unit.sv */
// Testbench top: clock, reset, stimulus and verdict for the resize unit.
module tb_bilinear_resize_rgb_normalize_unit;
	import rbn_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;
	int         fail_count;
	int         pending;
	int         stall_pct;
	int         stall_left;
	bit         no_gaps;
	bit         loaded_map [0:65535];

	rbn_req_if req_ch();
	rbn_rsp_if rsp_ch();

	bilinear_resize_rgb_normalize_unit dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	rbn_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Response side: random stalls, mostly short with a few long ones.
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
	end
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : 0;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// The run ends here if the block hangs.
	initial begin
		#30000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Drive one beat and hold it until the block takes it.
	task automatic send_beat(input logic cmd, input logic [15:0] idx, input logic [31:0] word,
		input logic [7:0] ox, input logic [7:0] oy);
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.pixel_index <= idx;
		req_ch.pixel_word  <= word;
		req_ch.out_column  <= ox;
		req_ch.out_row     <= oy;
		do @(posedge clk); while (!req_ch.ready);
		if (cmd == CMD_LOAD) loaded_map[idx] = 1'b1;
	endtask

	// Sender idle time: mostly none or short, now and then long.
	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = (no_gaps || r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Wait until every response has come and loads have left the pipeline.
	task automatic drain_block();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int unsigned dim_of(input logic [8:0] v);
		return (v == 0) ? 1 : (v > 256) ? 256 : v;
	endfunction

	// One setting: program it, fill the source region, then random traffic.
	task automatic run_setting(input logic [8:0] w, input logic [8:0] h, input logic [8:0] n,
		input int count);
		int unsigned region;
		int unsigned side;
		logic [7:0]  ox;
		logic [7:0]  oy;
		drain_block();
		write_reg(REG_SRC_W, w);
		write_reg(REG_SRC_H, h);
		write_reg(REG_OUT_N, n);
		region = dim_of(w) * dim_of(h);
		side = dim_of(n);
		for (int unsigned i = 0; i < region; i++) begin
			if (!loaded_map[i]) begin
				send_beat(CMD_LOAD, 16'(i), $urandom, 8'd0, 8'd0);
				sender_gap();
			end
		end
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 99) < 75) begin
				ox = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, side - 1))
					: 8'($urandom_range(0, 255));
				oy = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, side - 1))
					: 8'($urandom_range(0, 255));
				send_beat(CMD_PRODUCE, 16'($urandom), $urandom, ox, oy);
			end else if ($urandom_range(0, 3) != 0) begin
				send_beat(CMD_LOAD, 16'($urandom_range(0, region - 1)), $urandom,
					8'($urandom), 8'($urandom));
			end else begin
				send_beat(CMD_LOAD, 16'($urandom), $urandom, 8'($urandom), 8'($urandom));
			end
			sender_gap();
			// In the setting with a source width of 17, the sender holds off once, halfway, until the block has emptied.
			if (k == count / 2 && w == 9'd17) drain_block();
		end
	endtask

	initial begin
		req_ch.valid       = 1'b0;
		req_ch.command     = CMD_LOAD;
		req_ch.pixel_index = '0;
		req_ch.pixel_word  = '0;
		req_ch.out_column  = '0;
		req_ch.out_row     = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_SRC_W;
		cfg_data  = '0;
		no_gaps   = 1'b0;
		stall_pct = 20;
		arst_n    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizes: only coordinates outside the default output square.
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd224, 8'd0);
		send_beat(CMD_PRODUCE, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 8'd224);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd255, 8'd255);

		// Directed: 4x4 source, extreme pixel words, corners and edges.
		run_setting(9'd4, 9'd4, 9'd4, 0);
		send_beat(CMD_LOAD, 16'd0, 32'h0000_0000, 8'd0, 8'd0);
		send_beat(CMD_LOAD, 16'd15, 32'hFFFF_FFFF, 8'd0, 8'd0);
		send_beat(CMD_LOAD, 16'd5, 32'h00FF_00FF, 8'd0, 8'd0);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd0, 8'd0);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd3, 8'd3);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd0, 8'd3);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd3, 8'd0);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd1, 8'd2);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd4, 8'd0);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd0, 8'd4);
		// An unknown register index must change nothing.
		drain_block();
		write_reg(2'd3, 9'h1FF);
		send_beat(CMD_PRODUCE, 16'd0, 32'd0, 8'd2, 8'd1);

		// Random settings, the extremes among them.
		run_setting(9'd4, 9'd4, 9'd4, 120);
		run_setting(9'd1, 9'd1, 9'd1, 100);
		run_setting(9'd0, 9'd0, 9'd0, 60);
		run_setting(9'd300, 9'd1, 9'd256, 120);
		run_setting(9'd1, 9'd511, 9'd256, 120);
		stall_pct = 0;
		no_gaps   = 1'b1;
		run_setting(9'd17, 9'd13, 9'd37, 160);
		stall_pct = 50;
		no_gaps   = 1'b0;
		run_setting(9'd3, 9'd5, 9'd256, 120);
		stall_pct = 20;
		run_setting(9'd256, 9'd2, 9'd2, 120);
		run_setting(9'd2, 9'd256, 9'd200, 150);
		run_setting(9'd9, 9'd30, 9'd300, 120);

		drain_block();
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/rbn_pkg.sv
hdl/rbn_if.sv
hdl/rbn_div.sv
hdl/rbn_fetch.sv
hdl/rbn_norm.sv
hdl/bilinear_resize_rgb_normalize_unit.sv
tb/sv/rbn_checker.sv
tb/sv/tb_bilinear_resize_rgb_normalize_unit.sv
